// File: rtl/mefs_pkg.sv
// shared types, command and register codes for the address-exchange engine
// holds the frame window size and the byte-wide crc-8 step; no dependencies
package mefs_pkg;

    localparam int FRAME_BYTES = 9;
    localparam int LANE_CNT    = FRAME_BYTES - 1;
    localparam int FILL_W      = $clog2(FRAME_BYTES);
    localparam int ADDR_W      = 48;
    localparam int CFG_TIMER_W = 16;
    localparam int CFG_IDX_W   = 3;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_BYTE  = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PROBE_INTERVAL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_POLY       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_COMPLEMENT = 3'd5;

    localparam logic [2:0] SEND_NONE  = 3'd0;
    localparam logic [2:0] SEND_PROBE = 3'd1;
    localparam logic [2:0] SEND_REPLY = 3'd5;

    typedef struct packed {
        logic [ADDR_W-1:0]      own_address;
        logic [7:0]             header_byte;
        logic [CFG_TIMER_W-1:0] timeout_ms;
        logic [CFG_TIMER_W-1:0] probe_interval_ms;
        logic [7:0]             crc_poly;
        logic                   crc_complement;
    } t_cfg;

    typedef struct packed {
        logic       push;
        logic       clear;
        logic [7:0] data;
    } t_win_cmd;

    typedef struct packed {
        logic              busy;
        logic              capture;
        logic [ADDR_W-1:0] address;
        logic [7:0]        kind;
    } t_win_stat;

    // one byte through a reflected crc-8, lsb first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data,
                                             input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// File: rtl/mefs_cfg_regs.sv
// configuration register file of the address-exchange engine
// depends on mefs_pkg for register codes and the t_cfg struct
module mefs_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [mefs_pkg::CFG_IDX_W-1:0]    i_index,
    input  logic [mefs_pkg::ADDR_W-1:0]       i_data,
    output mefs_pkg::t_cfg                    o_cfg,
    output logic                              o_crc_write
);

    mefs_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.own_address       <= '0;
            r_cfg.header_byte       <= 8'd0;
            r_cfg.timeout_ms        <= 16'd5000;
            r_cfg.probe_interval_ms <= 16'd500;
            r_cfg.crc_poly          <= 8'd224;
            r_cfg.crc_complement    <= 1'b1;
        end else if (i_valid) begin
            case (i_index)
                mefs_pkg::CFG_OWN_ADDRESS:    r_cfg.own_address       <= i_data;
                mefs_pkg::CFG_HEADER_BYTE:    r_cfg.header_byte       <= i_data[7:0];
                mefs_pkg::CFG_TIMEOUT_MS:     r_cfg.timeout_ms        <= i_data[15:0];
                mefs_pkg::CFG_PROBE_INTERVAL: r_cfg.probe_interval_ms <= i_data[15:0];
                mefs_pkg::CFG_CRC_POLY:       r_cfg.crc_poly          <= i_data[7:0];
                mefs_pkg::CFG_CRC_COMPLEMENT: r_cfg.crc_complement    <= i_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg       = r_cfg;
    assign o_crc_write = i_valid && (i_index == mefs_pkg::CFG_CRC_POLY ||
                                     i_index == mefs_pkg::CFG_CRC_COMPLEMENT);

endmodule

// File: rtl/mefs_window.sv
// receive window: frame bytes, fill count and one running crc lane per start position
// depends on mefs_pkg for the window size, structs and crc8_byte
module mefs_window (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mefs_pkg::t_win_cmd             i_cmd,
    input  logic                           i_rebuild,
    input  logic [7:0]                     i_header,
    input  logic [mefs_pkg::ADDR_W-1:0]    i_own_address,
    input  logic [7:0]                     i_poly,
    input  logic                           i_complement,
    output mefs_pkg::t_win_stat            o_stat
);

    localparam int FB = mefs_pkg::FRAME_BYTES;
    localparam int LC = mefs_pkg::LANE_CNT;
    localparam int FW = mefs_pkg::FILL_W;

    logic [7:0]    r_bytes [0:FB-1];
    logic [7:0]    r_lane  [1:LC];
    logic [7:0]    upd     [1:LC];
    logic [7:0]    n_lane  [1:LC];
    logic [FW-1:0] r_fill;
    logic          r_rb_busy;
    logic [FW-1:0] r_rb_pos;

    logic [7:0]                  crc_init;
    logic [7:0]                  crc_fin;
    logic [7:0]                  rb_byte;
    logic                        rb_step;
    logic                        full;
    logic                        frame_ok;
    logic                        echo;
    logic [mefs_pkg::ADDR_W-1:0] win_addr;

    always_comb begin
        crc_init = i_complement ? 8'hFF : 8'h00;
        crc_fin  = i_complement ? ~r_lane[1] : r_lane[1];
        rb_byte  = r_bytes[r_rb_pos];
        rb_step  = r_rb_busy && (r_rb_pos < r_fill);
        full     = i_cmd.push && (r_fill == FW'(FB - 1));
        win_addr = {r_bytes[1], r_bytes[2], r_bytes[3], r_bytes[4], r_bytes[5], r_bytes[6]};
        frame_ok = (r_bytes[0] == i_header) && (crc_fin == i_cmd.data);
        echo     = (win_addr == i_own_address);
    end

    // lane j holds the crc of the bytes from window position j up to the fill point
    always_comb begin
        for (int j = 1; j <= LC; j++) begin
            upd[j] = r_lane[j];
            if (i_cmd.push) begin
                if (FW'(j) < r_fill) begin
                    upd[j] = mefs_pkg::crc8_byte(r_lane[j], i_cmd.data, i_poly);
                end else if (FW'(j) == r_fill) begin
                    upd[j] = mefs_pkg::crc8_byte(crc_init, i_cmd.data, i_poly);
                end
            end else if (rb_step) begin
                if (FW'(j) < r_rb_pos) begin
                    upd[j] = mefs_pkg::crc8_byte(r_lane[j], rb_byte, i_poly);
                end else if (FW'(j) == r_rb_pos) begin
                    upd[j] = mefs_pkg::crc8_byte(crc_init, rb_byte, i_poly);
                end
            end
        end
        for (int j = 1; j <= LC; j++) begin
            n_lane[j] = upd[j];
        end
        // a rejected full window slides, so every lane moves down one position
        if (full) begin
            for (int j = 1; j < LC; j++) begin
                n_lane[j] = upd[j + 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 1; j <= LC; j++) begin
            r_lane[j] <= n_lane[j];
        end
        if (i_cmd.push) begin
            if (!full) begin
                r_bytes[r_fill] <= i_cmd.data;
            end else if (!frame_ok) begin
                for (int k = 0; k < FB - 2; k++) begin
                    r_bytes[k] <= r_bytes[k + 1];
                end
                r_bytes[FB - 2] <= i_cmd.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.clear) begin
            r_fill <= '0;
        end else if (i_cmd.push) begin
            if (!full) begin
                r_fill <= r_fill + FW'(1);
            end else if (frame_ok) begin
                r_fill <= '0;
            end
        end
    end

    // after a crc setting changes, the lanes are rebuilt from the stored bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rb_busy <= 1'b0;
            r_rb_pos  <= '0;
        end else if (i_rebuild) begin
            r_rb_busy <= 1'b1;
            r_rb_pos  <= FW'(1);
        end else if (r_rb_busy) begin
            if (r_rb_pos < r_fill) begin
                r_rb_pos <= r_rb_pos + FW'(1);
            end else begin
                r_rb_busy <= 1'b0;
            end
        end
    end

    assign o_stat.busy    = r_rb_busy;
    assign o_stat.capture = full && frame_ok && !echo;
    assign o_stat.address = win_addr;
    assign o_stat.kind    = r_bytes[7];

endmodule

// File: rtl/mac_exchange_frame_sync.sv
// an accepted input transfer has its result registered in the output register in the next cycle
// throughput: one item per cycle unless o_stall is held; the output register frees in the cycle it is taken
// a write to the crc polynomial or complement stalls input while the crc lanes are
// rebuilt from the stored window bytes
// reset is synchronous, active low: engine disarmed, flags and timers cleared,
// configuration at its defaults, window empty
module mac_exchange_frame_sync #(
    parameter int TIMER_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [1:0]                        i_cmd,
    input  logic [7:0]                        i_rx_byte,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [2:0]                        o_send_frames,
    output logic                              o_exchange_active,
    output logic                              o_peer_found,
    output logic                              o_exchange_failed,
    output logic [47:0]                       o_peer_address,
    output logic [7:0]                        o_peer_kind,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mefs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mefs_pkg::ADDR_W-1:0]       i_cfg_data
);

    localparam int CMP_W = (TIMER_BITS > mefs_pkg::CFG_TIMER_W) ? TIMER_BITS
                                                                : mefs_pkg::CFG_TIMER_W;

    mefs_pkg::t_cfg      cfg;
    mefs_pkg::t_win_cmd  win_cmd;
    mefs_pkg::t_win_stat win_stat;
    logic                crc_write;
    logic                accept;

    logic                  r_armed,   n_armed;
    logic                  r_timed,   n_timed;
    logic                  r_found,   n_found;
    logic [TIMER_BITS-1:0] r_elapsed, n_elapsed;
    logic [TIMER_BITS-1:0] r_since,   n_since;
    logic [47:0]           r_addr,    n_addr;
    logic [7:0]            r_kind,    n_kind;
    logic [2:0]            n_send;
    logic [TIMER_BITS-1:0] el_inc;
    logic [TIMER_BITS-1:0] sp_inc;

    logic        r_out_valid;
    logic [2:0]  r_send;
    logic        r_out_armed;
    logic        r_out_found;
    logic        r_out_timed;
    logic [47:0] r_out_addr;
    logic [7:0]  r_out_kind;

    mefs_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_cfg_valid),
        .i_index     (i_cfg_index),
        .i_data      (i_cfg_data),
        .o_cfg       (cfg),
        .o_crc_write (crc_write)
    );

    mefs_window u_window (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (win_cmd),
        .i_rebuild     (crc_write),
        .i_header      (cfg.header_byte),
        .i_own_address (cfg.own_address),
        .i_poly        (cfg.crc_poly),
        .i_complement  (cfg.crc_complement),
        .o_stat        (win_stat)
    );

    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_out_valid && i_stall) || win_stat.busy;
    assign accept      = i_valid && !o_stall;

    always_comb begin
        n_armed      = r_armed;
        n_timed      = r_timed;
        n_found      = r_found;
        n_elapsed    = r_elapsed;
        n_since      = r_since;
        n_addr       = r_addr;
        n_kind       = r_kind;
        n_send       = mefs_pkg::SEND_NONE;
        win_cmd      = '0;
        win_cmd.data = i_rx_byte;
        el_inc       = (&r_elapsed) ? r_elapsed : r_elapsed + TIMER_BITS'(1);
        sp_inc       = (&r_since) ? r_since : r_since + TIMER_BITS'(1);
        if (accept) begin
            case (i_cmd)
                mefs_pkg::CMD_START: begin
                    n_armed       = 1'b1;
                    n_found       = 1'b0;
                    n_timed       = 1'b0;
                    n_elapsed     = '0;
                    n_since       = '1;
                    win_cmd.clear = 1'b1;
                end
                mefs_pkg::CMD_TICK: begin
                    if (r_armed) begin
                        n_elapsed = el_inc;
                        // timeout wins over a probe on the same tick
                        if (CMP_W'(el_inc) > CMP_W'(cfg.timeout_ms)) begin
                            n_armed = 1'b0;
                            n_timed = 1'b1;
                        end else if (CMP_W'(sp_inc) > CMP_W'(cfg.probe_interval_ms)) begin
                            n_since       = '0;
                            win_cmd.clear = 1'b1;
                            n_send        = mefs_pkg::SEND_PROBE;
                        end else begin
                            n_since = sp_inc;
                        end
                    end
                end
                mefs_pkg::CMD_BYTE: begin
                    if (r_armed) begin
                        win_cmd.push = 1'b1;
                        if (win_stat.capture) begin
                            n_addr  = win_stat.address;
                            n_kind  = win_stat.kind;
                            n_found = 1'b1;
                            n_armed = 1'b0;
                            n_send  = mefs_pkg::SEND_REPLY;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed   <= 1'b0;
            r_timed   <= 1'b0;
            r_found   <= 1'b0;
            r_elapsed <= '0;
            r_since   <= '0;
            r_addr    <= '0;
            r_kind    <= '0;
        end else begin
            r_armed   <= n_armed;
            r_timed   <= n_timed;
            r_found   <= n_found;
            r_elapsed <= n_elapsed;
            r_since   <= n_since;
            r_addr    <= n_addr;
            r_kind    <= n_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_send      <= n_send;
            r_out_armed <= n_armed;
            r_out_found <= n_found;
            r_out_timed <= n_timed;
            r_out_addr  <= n_found ? n_addr : 48'd0;
            r_out_kind  <= n_found ? n_kind : 8'd0;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_send_frames     = r_send;
    assign o_exchange_active = r_out_armed;
    assign o_peer_found      = r_out_found;
    assign o_exchange_failed = r_out_timed;
    assign o_peer_address    = r_out_addr;
    assign o_peer_kind       = r_out_kind;

`ifndef ASSERT_OFF
    // a reply request only comes with a fresh capture that ends the exchange
    a_reply_ends_exchange: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_send_frames == mefs_pkg::SEND_REPLY) |-> (o_peer_found && !o_exchange_active))
        else $error("reply request without capture");

    // a failed exchange is never still armed
    a_failed_disarmed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_exchange_failed) |-> !o_exchange_active)
        else $error("failed exchange still armed");

    // every accepted input transfer shows up in the output register in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_valid)
        else $error("accepted item produced no result");
`endif

endmodule

// File: tb/tb_mac_exchange_frame_sync.sv
`timescale 1ns / 100ps
// testbench for mac_exchange_frame_sync: drives start, tick, byte and nop commands plus
// register writes, predicts every status transfer in-bench and checks it field by field
// depends on mefs_pkg and the rtl top level only

module tb_mac_exchange_frame_sync;

    localparam int          TIMER_BITS   = 16;
    localparam int unsigned TIMER_MAX    = (1 << TIMER_BITS) - 1;
    localparam int          IDLE_LIMIT   = 1000;
    localparam int          RANDOM_ITEMS = 1450;
    localparam int          STEADY_ITEMS = 150;
    localparam int          PHASE_ITEMS  = 120;

    typedef struct packed {
        logic [2:0]                  send_frames;
        logic                        active;
        logic                        found;
        logic                        failed;
        logic [mefs_pkg::ADDR_W-1:0] peer_address;
        logic [7:0]                  peer_kind;
    } t_status;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_stall;
    logic [1:0]                     i_cmd;
    logic [7:0]                     i_rx_byte;
    logic                           o_valid;
    logic                           i_stall;
    logic [2:0]                     o_send_frames;
    logic                           o_exchange_active;
    logic                           o_peer_found;
    logic                           o_exchange_failed;
    logic [47:0]                    o_peer_address;
    logic [7:0]                     o_peer_kind;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [mefs_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [mefs_pkg::ADDR_W-1:0]    i_cfg_data;

    // model of the engine: configuration and state
    mefs_pkg::t_cfg              cfg_model;
    logic                        eng_armed;
    logic                        eng_failed;
    logic                        eng_found;
    int unsigned                 elapsed_ms;
    int unsigned                 probe_ms;
    logic [7:0]                  win [mefs_pkg::FRAME_BYTES];
    int                          win_fill;
    logic [mefs_pkg::ADDR_W-1:0] peer_addr;
    logic [7:0]                  peer_kind_q;

    t_status pending_status_q[$];
    int      mismatch_count = 0;
    int      items_sent     = 0;
    int      idle_cycles    = 0;
    bit      gaps_on        = 1'b0;

    mac_exchange_frame_sync #(
        .TIMER_BITS(TIMER_BITS)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_cmd            (i_cmd),
        .i_rx_byte        (i_rx_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_send_frames    (o_send_frames),
        .o_exchange_active(o_exchange_active),
        .o_peer_found     (o_peer_found),
        .o_exchange_failed(o_exchange_failed),
        .o_peer_address   (o_peer_address),
        .o_peer_kind      (o_peer_kind),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- prediction

    task automatic reset_engine_model();
        cfg_model.own_address       = '0;
        cfg_model.header_byte       = 8'h00;
        cfg_model.timeout_ms        = 16'd5000;
        cfg_model.probe_interval_ms = 16'd500;
        cfg_model.crc_poly          = 8'hE0;
        cfg_model.crc_complement    = 1'b1;
        eng_armed   = 1'b0;
        eng_failed  = 1'b0;
        eng_found   = 1'b0;
        elapsed_ms  = 0;
        probe_ms    = 0;
        win_fill    = 0;
        peer_addr   = '0;
        peer_kind_q = 8'h00;
        for (int i = 0; i < mefs_pkg::FRAME_BYTES; i++) win[i] = 8'h00;
    endtask

    // reflected crc-8 over address and kind bytes, first byte in the top lane
    function automatic logic [7:0] crc8_of(input logic [55:0] payload);
        logic [7:0] c;
        c = cfg_model.crc_complement ? 8'hFF : 8'h00;
        for (int i = 6; i >= 0; i--) begin
            c = c ^ payload[i*8 +: 8];
            for (int b = 0; b < 8; b++) begin
                c = c[0] ? ((c >> 1) ^ cfg_model.crc_poly) : (c >> 1);
            end
        end
        return cfg_model.crc_complement ? ~c : c;
    endfunction

    function automatic logic [2:0] window_push(input logic [7:0] v);
        logic [55:0] payload;
        if (win_fill < mefs_pkg::FRAME_BYTES) begin
            win[win_fill] = v;
            win_fill++;
        end
        if (win_fill < mefs_pkg::FRAME_BYTES) return mefs_pkg::SEND_NONE;
        payload = {win[1], win[2], win[3], win[4], win[5], win[6], win[7]};
        if (win[0] != cfg_model.header_byte || crc8_of(payload) != win[8]) begin
            // slide by one byte and wait for the next one
            for (int i = 0; i < mefs_pkg::FRAME_BYTES - 1; i++) win[i] = win[i+1];
            win_fill = mefs_pkg::FRAME_BYTES - 1;
            return mefs_pkg::SEND_NONE;
        end
        win_fill = 0;
        if (payload[55:8] == cfg_model.own_address) return mefs_pkg::SEND_NONE;
        peer_addr   = payload[55:8];
        peer_kind_q = payload[7:0];
        eng_found   = 1'b1;
        eng_armed   = 1'b0;
        return mefs_pkg::SEND_REPLY;
    endfunction

    function automatic logic [2:0] ms_tick();
        if (elapsed_ms < TIMER_MAX) elapsed_ms++;
        if (elapsed_ms > cfg_model.timeout_ms) begin
            eng_armed  = 1'b0;
            eng_failed = 1'b1;
            return mefs_pkg::SEND_NONE;
        end
        if (probe_ms < TIMER_MAX) probe_ms++;
        if (probe_ms > cfg_model.probe_interval_ms) begin
            probe_ms = 0;
            win_fill = 0;
            return mefs_pkg::SEND_PROBE;
        end
        return mefs_pkg::SEND_NONE;
    endfunction

    function automatic t_status predict_exchange_status(input logic [1:0] cmd,
                                                        input logic [7:0] rx);
        t_status s;
        logic [2:0] send;
        send = mefs_pkg::SEND_NONE;
        case (cmd)
            mefs_pkg::CMD_START: begin
                eng_armed  = 1'b1;
                eng_found  = 1'b0;
                eng_failed = 1'b0;
                win_fill   = 0;
                elapsed_ms = 0;
                probe_ms   = TIMER_MAX;
            end
            mefs_pkg::CMD_TICK: begin
                if (eng_armed) send = ms_tick();
            end
            mefs_pkg::CMD_BYTE: begin
                if (eng_armed) send = window_push(rx);
            end
            default: ;
        endcase
        s.send_frames  = send;
        s.active       = eng_armed;
        s.found        = eng_found;
        s.failed       = eng_failed;
        s.peer_address = eng_found ? peer_addr : '0;
        s.peer_kind    = eng_found ? peer_kind_q : 8'h00;
        return s;
    endfunction

    // ---------------------------------------------------------------- driving

    task automatic push_item(input logic [1:0] cmd, input logic [7:0] rx);
        int gap;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_cmd     <= cmd;
        i_rx_byte <= rx;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_status_q.push_back(predict_exchange_status(cmd, rx));
        items_sent++;
    endtask

    // frame: header, address msb first, kind, crc; corrupt flips one random bit
    task automatic send_frame(input logic [mefs_pkg::ADDR_W-1:0] addr, input logic [7:0] kind,
                              input bit corrupt);
        logic [71:0] frame;
        int flip;
        frame = {cfg_model.header_byte, addr, kind, crc8_of({addr, kind})};
        if (corrupt) begin
            flip = $urandom_range(0, 71);
            frame[flip] = ~frame[flip];
        end
        for (int i = mefs_pkg::FRAME_BYTES - 1; i >= 0; i--)
            push_item(mefs_pkg::CMD_BYTE, frame[i*8 +: 8]);
    endtask

    // drain every pending status, then give the engine a few quiet cycles
    task automatic settle();
        i_valid <= 1'b0;
        while (pending_status_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [mefs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mefs_pkg::ADDR_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            mefs_pkg::CFG_OWN_ADDRESS:    cfg_model.own_address       = data;
            mefs_pkg::CFG_HEADER_BYTE:    cfg_model.header_byte       = data[7:0];
            mefs_pkg::CFG_TIMEOUT_MS:     cfg_model.timeout_ms        = data[15:0];
            mefs_pkg::CFG_PROBE_INTERVAL: cfg_model.probe_interval_ms = data[15:0];
            mefs_pkg::CFG_CRC_POLY:       cfg_model.crc_poly          = data[7:0];
            mefs_pkg::CFG_CRC_COMPLEMENT: cfg_model.crc_complement    = data[0];
            default: ;
        endcase
    endtask

    // upper data bits of narrow registers carry junk that must be dropped
    task automatic apply_config(input logic [mefs_pkg::ADDR_W-1:0] own, input logic [7:0] hdr,
                                input logic [15:0] tmo, input logic [15:0] probe,
                                input logic [7:0] poly, input logic cmpl);
        logic [mefs_pkg::ADDR_W-1:0] junk;
        settle();
        junk = 48'({$urandom, $urandom});
        if ($urandom_range(0, 3) == 0)
            write_reg(mefs_pkg::CFG_CRC_COMPLEMENT + 3'($urandom_range(1, 2)), junk);
        write_reg(mefs_pkg::CFG_OWN_ADDRESS, own);
        write_reg(mefs_pkg::CFG_HEADER_BYTE, {junk[47:8], hdr});
        write_reg(mefs_pkg::CFG_TIMEOUT_MS, {junk[47:16], tmo});
        write_reg(mefs_pkg::CFG_PROBE_INTERVAL, {junk[47:16], probe});
        write_reg(mefs_pkg::CFG_CRC_POLY, {junk[47:8], poly});
        write_reg(mefs_pkg::CFG_CRC_COMPLEMENT, {junk[47:1], cmpl});
        i_cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what, input logic [47:0] got,
                                   input logic [47:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : status_check
        t_status want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_status_q.size() == 0) begin
                report_mismatch("unexpected transfer", 48'(o_send_frames), 48'h0);
            end else begin
                want = pending_status_q.pop_front();
                if (o_send_frames !== want.send_frames)
                    report_mismatch("send_frames", 48'(o_send_frames),
                                    48'(want.send_frames));
                if (o_exchange_active !== want.active)
                    report_mismatch("exchange_active", 48'(o_exchange_active),
                                    48'(want.active));
                if (o_peer_found !== want.found)
                    report_mismatch("peer_found", 48'(o_peer_found), 48'(want.found));
                if (o_exchange_failed !== want.failed)
                    report_mismatch("exchange_failed", 48'(o_exchange_failed),
                                    48'(want.failed));
                if (o_peer_address !== want.peer_address)
                    report_mismatch("peer_address", o_peer_address, want.peer_address);
                if (o_peer_kind !== want.peer_kind)
                    report_mismatch("peer_kind", 48'(o_peer_kind), 48'(want.peer_kind));
            end
        end
    end

    // receiver back-pressure in random bursts
    initial begin : out_stall_gen
        int run;
        run = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (run > 0) begin
                run--;
                i_stall <= 1'b1;
            end else if (gaps_on && $urandom_range(0, 7) == 0) begin
                run = $urandom_range(0, 12);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("** mac_exchange_frame_sync: FAILED **");
            $finish;
        end
    end

    // ---------------------------------------------------------------- tests

    // commands while disarmed only report the reset status
    task automatic test_disarmed_status();
        push_item(mefs_pkg::CMD_NOP, 8'h00);
        push_item(mefs_pkg::CMD_TICK, 8'hFF);
        push_item(mefs_pkg::CMD_BYTE, 8'hFF);
    endtask

    task automatic test_directed_exchange();
        push_item(mefs_pkg::CMD_START, 8'h5A);
        push_item(mefs_pkg::CMD_TICK, 8'h00);   // first tick after start probes
        push_item(mefs_pkg::CMD_BYTE, 8'hFF);   // stray byte, window has to slide once
        send_frame(48'hFFFF_FFFF_FFFF, 8'hFF, 1'b0);
        push_item(mefs_pkg::CMD_START, 8'h00);  // restart drops the captured peer from view
        send_frame(cfg_model.own_address, 8'h00, 1'b0);  // own echo is dropped
    endtask

    task automatic test_config_extremes();
        apply_config(48'hFFFF_FFFF_FFFF, 8'hFF, 16'd0, 16'd0, 8'h00, 1'b0);
        push_item(mefs_pkg::CMD_START, 8'h00);
        push_item(mefs_pkg::CMD_TICK, 8'h00);   // zero timeout fails on the first tick
        push_item(mefs_pkg::CMD_BYTE, 8'h00);
        apply_config(48'h0, 8'h00, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
        push_item(mefs_pkg::CMD_START, 8'h00);
        push_item(mefs_pkg::CMD_TICK, 8'h00);   // saturated probe timer never exceeds the max
        push_item(mefs_pkg::CMD_TICK, 8'h00);
        send_frame(48'({$urandom, $urandom}) | 48'h1, 8'h00, 1'b0);
        apply_config(48'({$urandom, $urandom}), 8'($urandom), 16'd6, 16'd0, 8'h8C, 1'b1);
        push_item(mefs_pkg::CMD_START, 8'h00);
        repeat (8) push_item(mefs_pkg::CMD_TICK, 8'h00);
        settle();
    endtask

    task automatic random_config();
        logic [15:0] tmo;
        logic [15:0] probe;
        logic [mefs_pkg::ADDR_W-1:0] own;
        case ($urandom_range(0, 5))
            0:       tmo = 16'd0;
            1:       tmo = 16'hFFFF;
            2:       tmo = 16'($urandom);
            default: tmo = 16'($urandom_range(1, 40));
        endcase
        case ($urandom_range(0, 5))
            0:       probe = 16'd0;
            1:       probe = 16'hFFFF;
            2:       probe = 16'($urandom);
            default: probe = 16'($urandom_range(1, 8));
        endcase
        case ($urandom_range(0, 5))
            0:       own = '0;
            1:       own = '1;
            default: own = 48'({$urandom, $urandom});
        endcase
        apply_config(own, 8'($urandom), tmo, probe, 8'($urandom), 1'($urandom));
    endtask

    // one exchange: start, then up to six rounds of frames, noise and ticks, mostly stopping once it ends
    task automatic run_session();
        int pick;
        int n;
        push_item(mefs_pkg::CMD_START, 8'($urandom));
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                send_frame(48'({$urandom, $urandom}), 8'($urandom), 1'b0);
            end else if (pick < 60) begin
                send_frame(cfg_model.own_address, 8'($urandom), 1'b0);
            end else if (pick < 75) begin
                send_frame(48'({$urandom, $urandom}), 8'($urandom), 1'b1);
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 4)) push_item(mefs_pkg::CMD_BYTE, 8'($urandom));
            end else if (pick < 95) begin
                repeat ($urandom_range(1, 3)) push_item(mefs_pkg::CMD_TICK, 8'($urandom));
            end else begin
                push_item($urandom_range(0, 1) ? mefs_pkg::CMD_NOP : mefs_pkg::CMD_START,
                          8'($urandom));
            end
            if (!eng_armed && $urandom_range(0, 3) != 0) break;
        end
    endtask

    task automatic test_random_exchanges(input int n_items, input bit allow_gaps);
        int goal;
        int phase_end;
        goal = items_sent + n_items;
        while (items_sent < goal) begin
            random_config();
            gaps_on   = allow_gaps && ($urandom_range(0, 3) != 0);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end && items_sent < goal) run_session();
        end
        settle();
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_cmd       <= mefs_pkg::CMD_NOP;
        i_rx_byte   <= 8'h00;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= mefs_pkg::CFG_OWN_ADDRESS;
        i_cfg_data  <= '0;
        reset_engine_model();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        gaps_on = 1'b1;
        test_disarmed_status();
        test_directed_exchange();
        test_config_extremes();
        test_random_exchanges(RANDOM_ITEMS, 1'b1);
        gaps_on = 1'b0;
        test_random_exchanges(STEADY_ITEMS, 1'b0);
        if (mismatch_count == 0) begin
            $display("** mac_exchange_frame_sync: PASSED **");
        end else begin
            $display("** mac_exchange_frame_sync: FAILED **");
        end
        $finish;
    end

endmodule

// File: mac_exchange_frame_sync.f
rtl/mefs_pkg.sv
rtl/mefs_cfg_regs.sv
rtl/mefs_window.sv
rtl/mac_exchange_frame_sync.sv
tb/tb_mac_exchange_frame_sync.sv
